// File: hw/rtl/frp_pkg.sv
// frp_pkg: shared types and codes for the feature record parser.
// Used by frp_parse, frp_out and feature_record_parser. No dependencies.
`timescale 1ns / 1ps

package frp_pkg;

  // Parse phases
  localparam logic [3:0] PH_HEADER     = 4'd0;
  localparam logic [3:0] PH_RIDGE      = 4'd1;
  localparam logic [3:0] PH_MASKED     = 4'd2;
  localparam logic [3:0] PH_SCORE      = 4'd3;
  localparam logic [3:0] PH_MINCNT     = 4'd4;
  localparam logic [3:0] PH_MIN        = 4'd5;
  localparam logic [3:0] PH_DARKCNT    = 4'd6;
  localparam logic [3:0] PH_DARK       = 4'd7;
  localparam logic [3:0] PH_BRIGHTCNT  = 4'd8;
  localparam logic [3:0] PH_BRIGHT     = 4'd9;
  localparam logic [3:0] PH_DONE       = 4'd10;
  localparam logic [3:0] PH_ERROR      = 4'd11;

  // Result kinds
  localparam logic [2:0] KIND_DIMS     = 3'd0;
  localparam logic [2:0] KIND_RIDGE    = 3'd1;
  localparam logic [2:0] KIND_MASKED   = 3'd2;
  localparam logic [2:0] KIND_SCORE    = 3'd3;
  localparam logic [2:0] KIND_MINUTIA  = 3'd4;
  localparam logic [2:0] KIND_DARK     = 3'd5;
  localparam logic [2:0] KIND_BRIGHT   = 3'd6;
  localparam logic [2:0] KIND_STATUS   = 3'd7;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_DIMS   = 2'd1;
  localparam logic [1:0] ST_TRUNCATED  = 2'd2;
  localparam logic [1:0] ST_OVER_AREA  = 2'd3;

  // Field sizes and the collection window
  localparam int FIELD_MAX     = 34;
  localparam int WIN_W         = FIELD_MAX * 8;
  localparam logic [5:0] SZ_WORD     = 6'd4;
  localparam logic [5:0] SZ_MINUTIA  = 6'd10;
  localparam logic [5:0] SZ_KEYPOINT = 6'd34;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic [31:0]        word_value;
    logic signed [15:0] pattern_or_orientation;
    logic [7:0]         kp_scale;
    logic signed [7:0]  kp_polarity;
    logic [63:0]        descriptor_low;
    logic [63:0]        descriptor_mid;
    logic [63:0]        descriptor_high;
    logic [1:0]         status;
    logic               last;
  } frp_result_t;

  // What one accepted byte produces: an optional data item, then an optional status
  typedef struct packed {
    logic        item_valid;
    frp_result_t item;
    logic        status_valid;
    logic [1:0]  status_code;
  } frp_step_t;

endpackage

// File: hw/rtl/feature_record_parser.sv
// feature_record_parser: top level of the streaming feature record parser.
// Depends on frp_pkg, frp_parse and frp_out.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   in      | into blk  | in_valid / in_ready  | data_byte, end_of_record
//   out     | from blk  | out_valid / out_ready| kind, x/y_value, word_value, keypoint
//           |           |                      | fields, descriptors, status, last
//
// One record byte per cycle while in_ready is high. Each accepted byte goes through
// one pass of decode logic and lands in the result stage the next cycle; a valid
// header, plane word, score or list entry gives a data transaction, and the final
// byte adds a status transaction behind it. The result stage holds two entries, so
// a byte that yields both a data item and a status item fills it; in_ready drops
// only then, or while out_ready is low with a result pending.
// Reset (rst, synchronous) returns the parse state to the header and empties the
// result stage; there is no clearing pass.
`timescale 1ns / 1ps

module feature_record_parser
  import frp_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  logic               clk,
  input  logic               rst,
  // byte stream
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_record,
  // result stream
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic signed [15:0] x_value,
  output logic signed [15:0] y_value,
  output logic [31:0]        word_value,
  output logic signed [15:0] pattern_or_orientation,
  output logic [7:0]         kp_scale,
  output logic signed [7:0]  kp_polarity,
  output logic [63:0]        descriptor_low,
  output logic [63:0]        descriptor_mid,
  output logic [63:0]        descriptor_high,
  output logic [1:0]         status,
  output logic               last
);

  logic        accept;
  logic        space;
  frp_step_t   step;
  frp_result_t result;

  // Accept a byte transaction only when the result stage can take its results
  assign in_ready = space;
  assign accept   = in_valid && space;

  frp_parse #(
    .MAX_SIDE (MAX_SIDE)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_record (end_of_record),
    .step          (step)
  );

  frp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .step      (step),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  // Fan the held result out to the payload ports
  assign kind                   = result.kind;
  assign x_value                = result.x_value;
  assign y_value                = result.y_value;
  assign word_value             = result.word_value;
  assign pattern_or_orientation = result.pattern_or_orientation;
  assign kp_scale               = result.kp_scale;
  assign kp_polarity            = result.kp_polarity;
  assign descriptor_low         = result.descriptor_low;
  assign descriptor_mid         = result.descriptor_mid;
  assign descriptor_high        = result.descriptor_high;
  assign status                 = result.status;
  assign last                   = result.last;

endmodule

// File: hw/rtl/frp_parse.sv
// frp_parse: byte collection window, parse state and field decode.
// Depends on frp_pkg.
`timescale 1ns / 1ps

module frp_parse
  import frp_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_record,
  output frp_step_t  step
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int RW_W   = $clog2((MAX_SIDE + 31) / 32 + 1);
  localparam int AREA_W = 2 * SIDE_W;

  // Parse state
  logic [3:0]        phase, phase_next;
  logic [5:0]        field_count, field_count_next;
  logic [AREA_W-1:0] pixel_area, pixel_area_next;
  logic [AREA_W-1:0] plane_count, plane_count_next;
  logic [AREA_W-1:0] items_left, items_left_next;
  logic [1:0]        error_code, error_code_next;

  // Byte shift line: newest byte at the top, a completed field sits at the top end
  logic [WIN_W-1:0]  shreg;
  logic [WIN_W-1:0]  win;

  logic              active;
  logic [5:0]        cnt_inc;
  logic [5:0]        field_size;
  logic              field_done;

  logic [15:0]       hdr_w, hdr_h;
  logic [SIDE_W-1:0] side_w, side_h;
  logic [16:0]       rw_full;
  logic [RW_W-1:0]   rw;
  logic [31:0]       word_top;
  logic [31:0]       count_val;
  logic [AREA_W-1:0] items_dec;
  frp_result_t       item;

  assign win    = {data_byte, shreg[WIN_W-1:8]};
  assign active = (phase < PH_DONE);

  assign hdr_w    = win[30*8 +: 16];
  assign hdr_h    = win[32*8 +: 16];
  assign side_w   = hdr_w[SIDE_W-1:0];
  assign side_h   = hdr_h[SIDE_W-1:0];
  assign rw_full  = ({1'b0, hdr_w} + 17'd31) >> 5;
  assign rw       = rw_full[RW_W-1:0];
  assign word_top = win[30*8 +: 32];
  assign count_val = word_top;
  assign items_dec = (items_left != '0) ? items_left - 1'b1 : items_left;
  assign cnt_inc   = field_count + 1'b1;

  always_comb begin
    unique case (phase)
      PH_MIN:              field_size = SZ_MINUTIA;
      PH_DARK, PH_BRIGHT:  field_size = SZ_KEYPOINT;
      default:             field_size = SZ_WORD;
    endcase
  end

  assign field_done = active && (cnt_inc >= field_size);

  always_comb begin
    phase_next       = phase;
    field_count_next = field_count;
    pixel_area_next  = pixel_area;
    plane_count_next = plane_count;
    items_left_next  = items_left;
    error_code_next  = error_code;
    item             = '0;
    step             = '0;

    if (accept) begin
      if (active) begin
        field_count_next = field_done ? 6'd0 : cnt_inc;
      end
      if (field_done) begin
        unique case (phase)
          PH_HEADER: begin
            if (hdr_w == 16'd0 || hdr_h == 16'd0 ||
                {1'b0, hdr_w} > 17'(MAX_SIDE) || {1'b0, hdr_h} > 17'(MAX_SIDE)) begin
              error_code_next = ST_BAD_DIMS;
              phase_next      = PH_ERROR;
            end else begin
              pixel_area_next  = AREA_W'(side_w) * AREA_W'(side_h);
              plane_count_next = AREA_W'(rw) * AREA_W'(side_h);
              items_left_next  = AREA_W'(rw) * AREA_W'(side_h);
              item.kind        = KIND_DIMS;
              item.x_value     = $signed(hdr_w);
              item.y_value     = $signed(hdr_h);
              step.item_valid  = 1'b1;
              phase_next       = PH_RIDGE;
            end
          end
          PH_RIDGE, PH_MASKED: begin
            item.kind       = (phase == PH_RIDGE) ? KIND_RIDGE : KIND_MASKED;
            item.word_value = word_top;
            step.item_valid = 1'b1;
            items_left_next = items_dec;
            if (items_dec == '0) begin
              if (phase == PH_RIDGE) begin
                items_left_next = plane_count;
                phase_next      = PH_MASKED;
              end else begin
                phase_next = PH_SCORE;
              end
            end
          end
          PH_SCORE: begin
            item.kind       = KIND_SCORE;
            item.word_value = word_top;
            step.item_valid = 1'b1;
            phase_next      = PH_MINCNT;
          end
          PH_MINCNT, PH_DARKCNT, PH_BRIGHTCNT: begin
            if (count_val > 32'(pixel_area)) begin
              error_code_next = ST_OVER_AREA;
              phase_next      = PH_ERROR;
            end else begin
              items_left_next = count_val[AREA_W-1:0];
              // empty list skips straight to the next count, or to done after the bright count
              phase_next = (count_val == 32'd0) ? phase + 4'd2 : phase + 4'd1;
            end
          end
          PH_MIN: begin
            item.kind                   = KIND_MINUTIA;
            item.x_value                = $signed(win[24*8 +: 16]);
            item.y_value                = $signed(win[26*8 +: 16]);
            item.word_value             = win[28*8 +: 32];
            item.pattern_or_orientation = $signed(win[32*8 +: 16]);
            step.item_valid             = 1'b1;
            items_left_next             = items_dec;
            if (items_dec == '0) begin
              phase_next = phase + 4'd1;
            end
          end
          PH_DARK, PH_BRIGHT: begin
            item.kind                   = (phase == PH_DARK) ? KIND_DARK : KIND_BRIGHT;
            item.x_value                = $signed(win[2*8 +: 16]);
            item.y_value                = $signed(win[4*8 +: 16]);
            item.kp_scale               = win[6*8 +: 8];
            item.kp_polarity            = $signed(win[7*8 +: 8]);
            item.pattern_or_orientation = $signed(win[8*8 +: 16]);
            item.descriptor_low         = win[10*8 +: 64];
            item.descriptor_mid         = win[18*8 +: 64];
            item.descriptor_high        = win[26*8 +: 64];
            step.item_valid             = 1'b1;
            items_left_next             = items_dec;
            if (items_dec == '0) begin
              phase_next = phase + 4'd1;
            end
          end
          default: begin
          end
        endcase
      end

      if (end_of_record) begin
        step.status_valid = 1'b1;
        if (error_code_next == ST_OK && phase_next != PH_DONE) begin
          step.status_code = ST_TRUNCATED;
        end else begin
          step.status_code = error_code_next;
        end
        // back to the start of a new record
        phase_next       = PH_HEADER;
        field_count_next = 6'd0;
        pixel_area_next  = '0;
        plane_count_next = '0;
        items_left_next  = '0;
        error_code_next  = ST_OK;
      end
    end
    step.item = item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      field_count <= 6'd0;
      pixel_area  <= '0;
      plane_count <= '0;
      items_left  <= '0;
      error_code  <= ST_OK;
    end else begin
      phase       <= phase_next;
      field_count <= field_count_next;
      pixel_area  <= pixel_area_next;
      plane_count <= plane_count_next;
      items_left  <= items_left_next;
      error_code  <= error_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active) begin
      shreg <= win;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_record |=> phase == PH_HEADER && field_count == 6'd0)
    else $error("parse state not cleared after final byte");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    field_count < 6'(FIELD_MAX))
    else $error("field byte count out of range");

  a_error_coded: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |-> error_code != ST_OK)
    else $error("error phase without error code");

endmodule

// File: hw/rtl/frp_out.sv
// frp_out: result stage holding one data item and one status item.
// Depends on frp_pkg.
`timescale 1ns / 1ps

module frp_out
  import frp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  frp_step_t   step,
  output logic        space,
  output logic        out_valid,
  input  logic        out_ready,
  output frp_result_t result
);

  logic        item_held;
  logic        status_held;
  frp_result_t item_reg;
  logic [1:0]  status_reg;
  frp_result_t status_item;

  // Take a new step when the stage is empty, or holds one entry that leaves now
  assign space = (!item_held && !status_held) ||
                 (out_ready && (item_held != status_held));

  always_comb begin
    status_item        = '0;
    status_item.kind   = KIND_STATUS;
    status_item.status = status_reg;
    status_item.last   = 1'b1;
  end

  assign out_valid = item_held || status_held;
  assign result    = item_held ? item_reg : status_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_held   <= 1'b0;
      status_held <= 1'b0;
    end else if (accept) begin
      item_held   <= step.item_valid;
      status_held <= step.status_valid;
    end else if (out_valid && out_ready) begin
      if (item_held) begin
        item_held <= 1'b0;
      end else begin
        status_held <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_reg   <= step.item;
      status_reg <= step.status_code;
    end
  end

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    item_held && status_held |-> !space)
    else $error("stage full but accepting");

  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    accept && (step.item_valid || step.status_valid) |=> out_valid)
    else $error("accepted step produced no pending result");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.last == (result.kind == KIND_STATUS)))
    else $error("last flag does not match status kind");

endmodule

// File: tb/feature_record_parser_tb.sv
// feature_record_parser_tb: self-checking testbench for the feature record parser.
// Needs frp_pkg and the feature_record_parser RTL; drives record byte streams and checks
// every result transaction against a built-in parse predictor.
`timescale 1ns / 1ps

module feature_record_parser_tb;
  import frp_pkg::*;

  localparam int MAX_SIDE       = 1024;
  localparam int TOTAL_BYTES    = 650;   // random records top the stream up to this
  localparam int TAIL_BYTES     = 60;    // no idling once this few bytes are left
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [7:0] data;
    logic       eor;
  } rec_byte_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte     = '0;
  logic               end_of_record = 1'b0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [2:0]         kind;
  logic signed [15:0] x_value;
  logic signed [15:0] y_value;
  logic [31:0]        word_value;
  logic signed [15:0] pattern_or_orientation;
  logic [7:0]         kp_scale;
  logic signed [7:0]  kp_polarity;
  logic [63:0]        descriptor_low;
  logic [63:0]        descriptor_mid;
  logic [63:0]        descriptor_high;
  logic [1:0]         status;
  logic               last;

  feature_record_parser #(
    .MAX_SIDE(MAX_SIDE)
  ) i_dut (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .data_byte              (data_byte),
    .end_of_record          (end_of_record),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .kind                   (kind),
    .x_value                (x_value),
    .y_value                (y_value),
    .word_value             (word_value),
    .pattern_or_orientation (pattern_or_orientation),
    .kp_scale               (kp_scale),
    .kp_polarity            (kp_polarity),
    .descriptor_low         (descriptor_low),
    .descriptor_mid         (descriptor_mid),
    .descriptor_high        (descriptor_high),
    .status                 (status),
    .last                   (last)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  rec_byte_t   byte_stream [$];       // bytes waiting to be driven
  frp_result_t expected_results [$];  // predicted result transactions, oldest first
  logic [7:0]  rec_q [$];             // record under construction
  int          errors = 0;
  int          quiet_cycles = 0;      // cycles with no transaction on either side
  logic [15:0] cyc = '0;
  logic        tail = 1'b0;           // end of the stream is near: stop idling
  int          in_gap = 0;
  int          out_gap = 0;

  // ---------------------------------------------------------------------------
  // Parse predictor: mirrors the record walk, one byte at a time
  // ---------------------------------------------------------------------------
  logic [3:0]  rec_phase;
  logic [5:0]  field_cnt;
  logic [7:0]  field_buf [0:FIELD_MAX-1];
  logic [10:0] frame_h;
  logic [5:0]  words_per_row;
  logic [20:0] area;
  logic [20:0] remaining;
  logic [1:0]  err_code;

  function automatic logic [15:0] le16(input int off);
    return {field_buf[off+1], field_buf[off]};
  endfunction

  function automatic logic [31:0] le32(input int off);
    return {le16(off + 2), le16(off)};
  endfunction

  function automatic logic [63:0] le64(input int off);
    return {le32(off + 4), le32(off)};
  endfunction

  task automatic reset_parse();
    rec_phase     = PH_HEADER;
    field_cnt     = '0;
    frame_h       = '0;
    words_per_row = '0;
    area          = '0;
    remaining     = '0;
    err_code      = ST_OK;
    foreach (field_buf[i]) field_buf[i] = '0;
  endtask

  // Count one item off the current list; advance to the next phase when it empties
  task automatic count_down(input logic [3:0] next_phase);
    if (remaining > 0) remaining--;
    if (remaining == 0) rec_phase = next_phase;
  endtask

  task automatic take_count(input logic [3:0] list_phase, input logic [3:0] skip_phase);
    logic [31:0] n;
    n = le32(0);
    if (n > 32'(area)) begin
      err_code  = ST_OVER_AREA;
      rec_phase = PH_ERROR;
    end else begin
      remaining = n[20:0];
      rec_phase = (n == 0) ? skip_phase : list_phase;
    end
  endtask

  task automatic close_field();
    frp_result_t r;
    int unsigned w;
    int unsigned h;
    r = '0;
    case (rec_phase)
      PH_HEADER: begin
        w = 32'(le16(0));
        h = 32'(le16(2));
        if (w == 0 || h == 0 || w > MAX_SIDE || h > MAX_SIDE) begin
          err_code  = ST_BAD_DIMS;
          rec_phase = PH_ERROR;
        end else begin
          frame_h       = h[10:0];
          words_per_row = 6'((w + 31) >> 5);
          area          = 21'(w * h);
          remaining     = 21'(((w + 31) >> 5) * h);
          r.kind        = KIND_DIMS;
          r.x_value     = 16'(w);
          r.y_value     = 16'(h);
          expected_results.push_back(r);
          rec_phase     = PH_RIDGE;
        end
      end
      PH_RIDGE: begin
        r.kind       = KIND_RIDGE;
        r.word_value = le32(0);
        expected_results.push_back(r);
        if (remaining > 0) remaining--;
        if (remaining == 0) begin
          // masked plane has the same word count as the ridge plane
          remaining = 21'(int'(words_per_row) * int'(frame_h));
          rec_phase = PH_MASKED;
        end
      end
      PH_MASKED: begin
        r.kind       = KIND_MASKED;
        r.word_value = le32(0);
        expected_results.push_back(r);
        count_down(PH_SCORE);
      end
      PH_SCORE: begin
        r.kind       = KIND_SCORE;
        r.word_value = le32(0);
        expected_results.push_back(r);
        rec_phase    = PH_MINCNT;
      end
      PH_MINCNT:    take_count(PH_MIN, PH_DARKCNT);
      PH_DARKCNT:   take_count(PH_DARK, PH_BRIGHTCNT);
      PH_BRIGHTCNT: take_count(PH_BRIGHT, PH_DONE);
      PH_MIN: begin
        r.kind                   = KIND_MINUTIA;
        r.x_value                = le16(0);
        r.y_value                = le16(2);
        r.word_value             = le32(4);
        r.pattern_or_orientation = le16(8);
        expected_results.push_back(r);
        count_down(PH_DARKCNT);
      end
      PH_DARK, PH_BRIGHT: begin
        // bytes 0 and 1 of a keypoint carry nothing we report
        r.kind                   = (rec_phase == PH_DARK) ? KIND_DARK : KIND_BRIGHT;
        r.x_value                = le16(2);
        r.y_value                = le16(4);
        r.kp_scale               = field_buf[6];
        r.kp_polarity            = field_buf[7];
        r.pattern_or_orientation = le16(8);
        r.descriptor_low         = le64(10);
        r.descriptor_mid         = le64(18);
        r.descriptor_high        = le64(26);
        expected_results.push_back(r);
        count_down((rec_phase == PH_DARK) ? PH_BRIGHTCNT : PH_DONE);
      end
      default: ;
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eor);
    frp_result_t r;
    logic [5:0]  fsize;
    if (rec_phase < PH_DONE) begin
      if (rec_phase == PH_MIN)
        fsize = SZ_MINUTIA;
      else if (rec_phase == PH_DARK || rec_phase == PH_BRIGHT)
        fsize = SZ_KEYPOINT;
      else
        fsize = SZ_WORD;
      field_buf[field_cnt] = b;
      field_cnt++;
      if (field_cnt >= fsize) begin
        field_cnt = '0;
        close_field();
      end
    end
    // the final byte is parsed first, then the status transaction follows it
    if (eor) begin
      r        = '0;
      r.kind   = KIND_STATUS;
      r.status = err_code;
      if (err_code == ST_OK && rec_phase != PH_DONE) r.status = ST_TRUNCATED;
      r.last   = 1'b1;
      expected_results.push_back(r);
      reset_parse();
    end
  endtask

  initial reset_parse();

  // ---------------------------------------------------------------------------
  // Record construction
  // ---------------------------------------------------------------------------
  task automatic add8(input logic [7:0] v);
    rec_q.push_back(v);
  endtask

  task automatic add16(input logic [15:0] v);
    add8(v[7:0]);
    add8(v[15:8]);
  endtask

  task automatic add32(input logic [31:0] v);
    add16(v[15:0]);
    add16(v[31:16]);
  endtask

  task automatic add_rand(input int n);
    repeat (n) add8(8'($urandom));
  endtask

  // Lay out a record; stop right after a field that makes the parser give up
  task automatic build_record(input logic [15:0] w, input logic [15:0] h,
                              input logic [31:0] c_min, input logic [31:0] c_dark,
                              input logic [31:0] c_bright);
    int unsigned area_v;
    int unsigned words;
    rec_q.delete();
    add16(w);
    add16(h);
    if (w == 0 || h == 0 || w > MAX_SIDE || h > MAX_SIDE) return;
    area_v = 32'(w) * 32'(h);
    words  = ((32'(w) + 31) >> 5) * 32'(h);
    add_rand(8 * words);          // ridge plane, then masked plane
    add32($urandom);              // feature score
    add32(c_min);
    if (c_min > area_v) return;
    add_rand(10 * c_min);
    add32(c_dark);
    if (c_dark > area_v) return;
    add_rand(34 * c_dark);
    add32(c_bright);
    if (c_bright > area_v) return;
    add_rand(34 * c_bright);
  endtask

  // Cut the record to a given length (0 keeps it whole), append junk, and queue it
  task automatic commit_record(input int cut, input int trail);
    rec_byte_t item;
    if (cut > 0)
      while (rec_q.size() > cut) void'(rec_q.pop_back());
    add_rand(trail);
    foreach (rec_q[i]) begin
      item.data = rec_q[i];
      item.eor  = (i == rec_q.size() - 1);
      byte_stream.push_back(item);
    end
  endtask

  task automatic raw_header(input logic [15:0] w, input logic [15:0] h, input int extra);
    rec_q.delete();
    add16(w);
    add16(h);
    add_rand(extra);
    commit_record(0, 0);
  endtask

  task automatic directed_records();
    // smallest legal frame, all lists empty
    build_record(1, 1, 0, 0, 0);            commit_record(0, 0);
    // final byte closes a bright keypoint: data transaction and status together
    build_record(32, 1, 1, 0, 1);           commit_record(0, 0);
    // two words per row, junk after the bright list
    build_record(33, 1, 2, 0, 1);           commit_record(0, 3);
    // list count equal to the area is still legal
    build_record(1, 2, 2, 0, 0);            commit_record(0, 0);
    // widest frame with one row, cut just past the end of the ridge plane
    build_record(MAX_SIDE, 1, 0, 0, 0);     commit_record(4 + 4 * 32 + 4, 0);
    // bad dimensions: zero, just above the limit, all ones
    raw_header(16'd0, 16'd5, 2);
    raw_header(16'd7, 16'd0, 0);
    raw_header(16'(MAX_SIDE + 1), 16'd1, 1);
    raw_header(16'hFFFF, 16'hFFFF, 1);
    // largest legal frame, cut off inside the ridge plane
    raw_header(16'(MAX_SIDE), 16'(MAX_SIDE), 10);
    // counts above the area, one per list
    build_record(2, 2, 5, 0, 0);            commit_record(0, 3);
    build_record(3, 1, 0, 32'hFFFF_FFFF, 0); commit_record(0, 0);
    build_record(1, 1, 0, 1, 2);            commit_record(0, 2);
    // early ends: inside the header, on a count boundary, mid-keypoint
    rec_q.delete(); add8(8'hA5);            commit_record(0, 0);
    build_record(5, 1, 0, 1, 0);            commit_record(4 + 8 + 4, 0);
    build_record(5, 1, 0, 1, 0);            commit_record(4 + 8 + 4 + 8 + 20, 0);
  endtask

  task automatic random_records();
    int          sel;
    int unsigned w;
    int unsigned h;
    logic [31:0] c [3];
    logic [31:0] over;
    while (byte_stream.size() < TOTAL_BYTES) begin
      sel = $urandom_range(0, 99);
      // mostly small frames; now and then a wide single-row one
      if ($urandom_range(0, 19) == 0) begin
        w = $urandom_range(65, MAX_SIDE);
        h = 1;
      end else begin
        w = $urandom_range(1, 64);
        h = $urandom_range(1, 3);
      end
      c[0] = $urandom_range(0, 3);
      c[1] = $urandom_range(0, 1);
      c[2] = $urandom_range(0, 2);
      if (sel < 70) begin
        build_record(16'(w), 16'(h), c[0], c[1], c[2]);
        commit_record(0, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
      end else if (sel < 80) begin
        build_record(16'(w), 16'(h), c[0], c[1], c[2]);
        commit_record($urandom_range(1, rec_q.size()), 0);
      end else if (sel < 87) begin
        over = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'(w * h + 1 + $urandom_range(0, 500));
        c[$urandom_range(0, 2)] = over;
        build_record(16'(w), 16'(h), c[0], c[1], c[2]);
        commit_record(0, $urandom_range(0, 5));
      end else if (sel < 94) begin
        case ($urandom_range(0, 2))
          0: w = 0;
          1: h = 0;
          default: w = $urandom_range(MAX_SIDE + 1, 16'hFFFF);
        endcase
        raw_header(16'(w), 16'(h), $urandom_range(0, 6));
      end else begin
        // plain noise; usually dies in the header
        rec_q.delete();
        add_rand($urandom_range(1, 12));
        commit_record(0, 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: hold valid and payload until accepted, then advance
  // ---------------------------------------------------------------------------
  rec_byte_t next_byte;

  always @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      data_byte     <= '0;
      end_of_record <= 1'b0;
      in_gap        <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_stream.size() > 0) begin
        next_byte = byte_stream.pop_front();
        in_valid      <= 1'b1;
        data_byte     <= next_byte.data;
        end_of_record <= next_byte.eor;
        // idle bursts come only in busy stretches and never near the end
        if (!tail && cyc[7] && $urandom_range(0, 5) == 0)
          in_gap <= $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
    tail <= (byte_stream.size() < TAIL_BYTES);
  end

  // Result-side backpressure: stall in random bursts during busy stretches
  always @(posedge clk) begin
    cyc <= cyc + 1'b1;
    if (out_gap > 0) begin
      out_gap   <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!rst && !tail && !cyc[7] && $urandom_range(0, 5) == 0)
        out_gap <= $urandom_range(1, 11);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every byte transaction, check every result transaction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  frp_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      // predict first so a same-cycle result would still find its expectation
      if (in_valid && in_ready) parse_byte(data_byte, end_of_record);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: kind %0d status %0d last %0b",
                   $time, kind, status, last);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 64'(want.kind), 64'(kind));
          check_field("x_value", 64'(want.x_value), 64'(x_value));
          check_field("y_value", 64'(want.y_value), 64'(y_value));
          check_field("word_value", 64'(want.word_value), 64'(word_value));
          check_field("pattern_or_orientation", 64'(want.pattern_or_orientation),
                      64'(pattern_or_orientation));
          check_field("kp_scale", 64'(want.kp_scale), 64'(kp_scale));
          check_field("kp_polarity", 64'(want.kp_polarity), 64'(kp_polarity));
          check_field("descriptor_low", want.descriptor_low, descriptor_low);
          check_field("descriptor_mid", want.descriptor_mid, descriptor_mid);
          check_field("descriptor_high", want.descriptor_high, descriptor_high);
          check_field("status", 64'(want.status), 64'(status));
          check_field("last", 64'(want.last), 64'(last));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: end the run if nothing moves for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("feature_record_parser_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    directed_records();
    random_records();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // sample on the falling edge, clear of the clocked blocks
    do @(negedge clk); while (byte_stream.size() > 0 || in_valid);
    while (expected_results.size() > 0) @(negedge clk);
    // let any stray result surface
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("feature_record_parser_tb: PASS");
    end else begin
      $display("feature_record_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
